// ===== rtl/ata_chs_lba_sector_addresser_core_macros.svh =====
// assertion macros shared by the checker of the sector addresser core
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef ATA_CHS_LBA_SECTOR_ADDRESSER_CORE_MACROS_SVH
`define ATA_CHS_LBA_SECTOR_ADDRESSER_CORE_MACROS_SVH

// same-cycle implication
`define ATALBA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define ATALBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/atalba_pkg.sv =====
// types, codes and constants of the ata chs/lba sector addresser
// no dependencies; imported by every module of the block
package atalba_pkg;

    localparam int SEC_W      = 8;
    localparam int CYL_W      = 16;
    localparam int HEAD_W     = 4;
    localparam int COUNT_W    = 8;
    localparam int ADDR_W     = 28;
    localparam int POS_W      = 32;
    localparam int CFG_DATA_W = 28;
    localparam int GHEADS_W   = 5;
    localparam int ACYL_W     = 28;
    localparam int DIV_W      = 13;
    localparam int PROD_W     = 22;
    localparam int MUL2_W     = 30;

    localparam int DIV_STEPS  = ADDR_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int MAX_HEAD = 15;

    localparam logic [ACYL_W-1:0]   RST_CYLINDERS = ACYL_W'(1024);
    localparam logic [GHEADS_W-1:0] RST_HEADS     = GHEADS_W'(16);
    localparam logic [SEC_W-1:0]    RST_SECTORS   = SEC_W'(63);
    localparam logic [ADDR_W-1:0]   RST_CAPACITY  = ADDR_W'(1032192);

    typedef enum logic [1:0] {
        CMD_SEEK    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_INIT    = 2'd2,
        CMD_RECAL   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_GEOM  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_CYLINDERS = 2'd0,
        REG_HEADS     = 2'd1,
        REG_SECTORS   = 2'd2,
        REG_CAPACITY  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_SEEK_LBA,
        OP_SEEK_CHS,
        OP_ADV_LBA,
        OP_ADV_CHS,
        OP_INIT,
        OP_RECAL
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV
    } state_t;

    typedef struct packed {
        op_t                op;
        logic               lba;
        logic [SEC_W-1:0]   sec;
        logic [CYL_W-1:0]   cyl;
        logic [HEAD_W-1:0]  head;
        logic [COUNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

    typedef struct packed {
        logic                  we;
        reg_idx_t              index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ===== rtl/ata_chs_lba_sector_addresser_core.sv =====
// ata sector addressing unit: chs/lba seek check, sector advance,
// recalibrate and initialize device parameters, one result per request.
// input channel in_valid/in_ready carries cmd and the task-file address;
// output channel out_valid/out_ready carries position, status and next address.
// configuration: cfg_we with cfg_index 0..3 (cylinders, heads, sectors,
// capacity) writes at once; geometry writes also load the active geometry.
// a request enters a two-deep queue the cycle it is accepted; the executor
// pops it when idle with the output free, and registers the result:
//   recalibrate, advance, lba seek, failed chs seek: from the execute state
//   chs seek: after two registered multiplies
//   init parameters: 28-step serial divider on capacity; a zero count fails at once
// requests are executed one at a time; the next is popped only after the
// result of the last one is registered.
// reset empties the queue and loads geometry 1024/16/63, capacity 1032192.
// a stalled result holds in the output register; the queue keeps taking
// requests until full, then in_ready drops.
// depends on atalba_pkg, atalba_front, atalba_fifo and atalba_back
module ata_chs_lba_sector_addresser_core
    import atalba_pkg::*;
#(
    parameter int LBA_BITS = 28
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [SEC_W-1:0]      sector_reg,
    input  logic [CYL_W-1:0]      cyl_reg,
    input  logic [HEAD_W-1:0]     head_reg,
    input  logic                  lba_mode,
    input  logic [COUNT_W-1:0]    sector_count_reg,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POS_W-1:0]      position,
    output logic [1:0]            status_code,
    output logic [SEC_W-1:0]      next_sector_reg,
    output logic [CYL_W-1:0]      next_cyl_reg,
    output logic [HEAD_W-1:0]     next_head_reg,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    q_full;
    logic    push;
    item_t   push_item;
    logic    pop;
    q_out_t  q_out;
    cfg_wr_t cfg;
    status_t status_q;

    assign cfg.we    = cfg_we;
    assign cfg.index = reg_idx_t'(cfg_index);
    assign cfg.data  = cfg_data;

    atalba_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .sector_reg       (sector_reg),
        .cyl_reg          (cyl_reg),
        .head_reg         (head_reg),
        .lba_mode         (lba_mode),
        .sector_count_reg (sector_count_reg),
        .q_full           (q_full),
        .push             (push),
        .push_item        (push_item)
    );

    atalba_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_out     (q_out)
    );

    atalba_back #(
        .LBA_BITS (LBA_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_out           (q_out),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .position        (position),
        .status_code     (status_q),
        .next_sector_reg (next_sector_reg),
        .next_cyl_reg    (next_cyl_reg),
        .next_head_reg   (next_head_reg)
    );

    assign status_code = status_q;

endmodule

// ===== rtl/atalba_fifo.sv =====
// short request queue between the front decoder and the back executor
// depends on atalba_pkg for the item type and the queue depth
module atalba_fifo
    import atalba_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  item_t  push_item,
    output logic   full,
    input  logic   pop,
    output q_out_t q_out
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && (cnt_reg != '0);

    assign q_out.valid = (cnt_reg != '0);
    assign q_out.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = QCNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = QCNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/atalba_front.sv =====
// front end: takes requests and sorts each into an operation for the back end
// depends on atalba_pkg for command codes and the queued item type
module atalba_front
    import atalba_pkg::*;
(
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [SEC_W-1:0]   sector_reg,
    input  logic [CYL_W-1:0]   cyl_reg,
    input  logic [HEAD_W-1:0]  head_reg,
    input  logic               lba_mode,
    input  logic [COUNT_W-1:0] sector_count_reg,
    input  logic               q_full,
    output logic               push,
    output item_t              push_item
);

    op_t op;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        case (cmd_t'(cmd))
            CMD_SEEK:    op = lba_mode ? OP_SEEK_LBA : OP_SEEK_CHS;
            CMD_ADVANCE: op = lba_mode ? OP_ADV_LBA : OP_ADV_CHS;
            CMD_INIT:    op = OP_INIT;
            CMD_RECAL:   op = OP_RECAL;
            default:     op = OP_RECAL;
        endcase
    end

    always_comb
    begin
        push_item.op    = op;
        push_item.lba   = lba_mode;
        push_item.sec   = sector_reg;
        push_item.cyl   = cyl_reg;
        push_item.head  = head_reg;
        push_item.count = sector_count_reg;
    end

endmodule

// ===== rtl/atalba_back.sv =====
// back end: executes queued operations against the active geometry
// depends on atalba_pkg; holds geometry, capacity, the divider and the result register
module atalba_back
    import atalba_pkg::*;
#(
    parameter int LBA_BITS = 28
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_wr_t            cfg,
    input  q_out_t             q_out,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [POS_W-1:0]   position,
    output status_t            status_code,
    output logic [SEC_W-1:0]   next_sector_reg,
    output logic [CYL_W-1:0]   next_cyl_reg,
    output logic [HEAD_W-1:0]  next_head_reg
);

    localparam logic [ADDR_W-1:0] LBA_MASK = ADDR_W'((64'd1 << LBA_BITS) - 64'd1);

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [ADDR_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [ACYL_W-1:0]     acyl_reg, acyl_next;
    logic [GHEADS_W-1:0]   aheads_reg, aheads_next;
    logic [SEC_W-1:0]      asec_reg, asec_next;
    logic [ADDR_W-1:0]     cap_reg, cap_next;
    logic                  out_valid_reg, out_valid_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    status_t               status_reg, status_next;
    logic [SEC_W-1:0]      nsec_reg, nsec_next;
    logic [CYL_W-1:0]      ncyl_reg, ncyl_next;
    logic [HEAD_W-1:0]     nhead_reg, nhead_next;

    logic                  out_free;
    logic [ADDR_W-1:0]     addr, addr_masked, addr_inc;
    logic                  chs_fail;
    logic [GHEADS_W-1:0]   head_inc;
    logic                  head_carry;
    logic [PROD_W-1:0]     prod_chs;
    logic [MUL2_W-1:0]     mul2;
    logic [POS_W-1:0]      pos_chs;
    logic [DIV_W-1:0]      div_init;
    logic [DIV_W:0]        trial;
    logic                  trial_ge;
    logic [DIV_W-1:0]      rem_step;
    logic [ADDR_W-1:0]     quo_step;

    assign out_free = !out_valid_reg || out_ready;

    // address arithmetic on the held request
    assign addr        = {item_reg.head, item_reg.cyl, item_reg.sec};
    assign addr_masked = addr & LBA_MASK;
    assign addr_inc    = (addr & ~LBA_MASK) | (ADDR_W'(addr + 1'b1) & LBA_MASK);

    assign chs_fail = (ACYL_W'(item_reg.cyl) >= acyl_reg)
                   || (GHEADS_W'(item_reg.head) >= aheads_reg)
                   || (item_reg.sec > asec_reg)
                   || (item_reg.sec == '0);

    assign head_inc   = GHEADS_W'(GHEADS_W'(item_reg.head) + 1'b1);
    assign head_carry = !((head_inc < aheads_reg) && (head_inc <= GHEADS_W'(MAX_HEAD)));

    // cyl * heads + head, registered before the multiply by sectors
    assign prod_chs = PROD_W'(PROD_W'(PROD_W'(item_reg.cyl) * PROD_W'(aheads_reg))
                    + PROD_W'(item_reg.head));
    assign mul2     = MUL2_W'(prod_reg) * MUL2_W'(asec_reg);
    assign pos_chs  = POS_W'(POS_W'(mul2) + POS_W'(item_reg.sec) - POS_W'(1));

    // capacity / count / heads taken as one division by count * heads
    assign div_init = DIV_W'(DIV_W'(item_reg.count) * DIV_W'(head_inc));

    // restoring divider, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[ADDR_W-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});
    assign rem_step = trial_ge ? DIV_W'(trial - {1'b0, div_reg}) : DIV_W'(trial);
    assign quo_step = {quo_reg[ADDR_W-2:0], trial_ge};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_out.valid && out_free)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (item_reg.op)
                    OP_SEEK_CHS: state_next = chs_fail ? ST_IDLE : ST_MUL;
                    OP_INIT:     state_next = (item_reg.count == '0) ? ST_IDLE : ST_DIV;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_MUL:
            begin
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        item_next      = item_reg;
        prod_next      = prod_reg;
        div_next       = div_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        acyl_next      = acyl_reg;
        aheads_next    = aheads_reg;
        asec_next      = asec_reg;
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        nsec_next      = nsec_reg;
        ncyl_next      = ncyl_reg;
        nhead_next     = nhead_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_out.valid && out_free)
                begin
                    pop       = 1'b1;
                    item_next = q_out.item;
                end
            end
            ST_EXEC:
            begin
                // most operations finish here with the address passed through
                pos_next    = '0;
                status_next = STATUS_OK;
                nsec_next   = item_reg.sec;
                ncyl_next   = item_reg.cyl;
                nhead_next  = item_reg.head;
                case (item_reg.op)
                    OP_SEEK_LBA:
                    begin
                        out_valid_next = 1'b1;
                        if (addr_masked >= cap_reg)
                        begin
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            pos_next = POS_W'(addr_masked);
                        end
                    end
                    OP_SEEK_CHS:
                    begin
                        prod_next = prod_chs;
                        if (chs_fail)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_RANGE;
                        end
                    end
                    OP_ADV_LBA:
                    begin
                        out_valid_next = 1'b1;
                        nsec_next      = addr_inc[SEC_W-1:0];
                        ncyl_next      = addr_inc[SEC_W +: CYL_W];
                        nhead_next     = addr_inc[ADDR_W-1 -: HEAD_W];
                    end
                    OP_ADV_CHS:
                    begin
                        out_valid_next = 1'b1;
                        if (item_reg.sec < asec_reg)
                        begin
                            nsec_next = SEC_W'(item_reg.sec + 1'b1);
                        end
                        else
                        begin
                            nsec_next = SEC_W'(1);
                            if (head_carry)
                            begin
                                nhead_next = '0;
                                ncyl_next  = CYL_W'(item_reg.cyl + 1'b1);
                            end
                            else
                            begin
                                nhead_next = head_inc[HEAD_W-1:0];
                            end
                        end
                    end
                    OP_INIT:
                    begin
                        aheads_next = head_inc;
                        asec_next   = item_reg.count;
                        div_next    = div_init;
                        quo_next    = cap_reg;
                        rem_next    = '0;
                        step_next   = STEP_W'(DIV_STEPS - 1);
                        if (item_reg.count == '0)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_GEOM;
                        end
                    end
                    OP_RECAL:
                    begin
                        out_valid_next = 1'b1;
                        nsec_next      = item_reg.lba ? SEC_W'(0) : SEC_W'(1);
                        ncyl_next      = '0;
                        nhead_next     = '0;
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                    end
                endcase
            end
            ST_MUL:
            begin
                out_valid_next = 1'b1;
                pos_next       = pos_chs;
                status_next    = STATUS_OK;
                nsec_next      = item_reg.sec;
                ncyl_next      = item_reg.cyl;
                nhead_next     = item_reg.head;
            end
            ST_DIV:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = STEP_W'(step_reg - 1'b1);
                if (step_reg == '0)
                begin
                    acyl_next      = quo_step;
                    out_valid_next = 1'b1;
                    pos_next       = '0;
                    status_next    = STATUS_OK;
                    nsec_next      = item_reg.sec;
                    ncyl_next      = item_reg.cyl;
                    nhead_next     = item_reg.head;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase

        // geometry writes also load the active geometry
        if (cfg.we)
        begin
            case (cfg.index)
                REG_CYLINDERS: acyl_next   = ACYL_W'(cfg.data[CYL_W-1:0]);
                REG_HEADS:     aheads_next = cfg.data[GHEADS_W-1:0];
                REG_SECTORS:   asec_next   = cfg.data[SEC_W-1:0];
                REG_CAPACITY:  cap_next    = cfg.data[ADDR_W-1:0];
                default:       cap_next    = cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acyl_reg      <= RST_CYLINDERS;
            aheads_reg    <= RST_HEADS;
            asec_reg      <= RST_SECTORS;
            cap_reg       <= RST_CAPACITY;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acyl_reg      <= acyl_next;
            aheads_reg    <= aheads_next;
            asec_reg      <= asec_next;
            cap_reg       <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        prod_reg   <= prod_next;
        div_reg    <= div_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        nsec_reg   <= nsec_next;
        ncyl_reg   <= ncyl_next;
        nhead_reg  <= nhead_next;
    end

    assign out_valid       = out_valid_reg;
    assign position        = pos_reg;
    assign status_code     = status_reg;
    assign next_sector_reg = nsec_reg;
    assign next_cyl_reg    = ncyl_reg;
    assign next_head_reg   = nhead_reg;

endmodule

// ===== rtl/atalba_checker.sv =====
// port-level checks on the sector addresser core, bound to the top level
// depends on atalba_pkg and the assertion macros header
`include "ata_chs_lba_sector_addresser_core_macros.svh"

module atalba_checker
    import atalba_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [POS_W-1:0] position,
    input logic [1:0]       status_code
);

    // a result with a failed check never carries a position
    `ATALBA_ASSERT(a_err_no_position, out_valid && (status_code != STATUS_OK), position == '0)

    // chs positions stay below 2^30 for any geometry, lba ones below 2^28
    `ATALBA_ASSERT(a_position_range, out_valid, position[POS_W-1:POS_W-2] == 2'b00)

    // a stalled result holds
    `ATALBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(status_code))

endmodule

bind ata_chs_lba_sector_addresser_core atalba_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .status_code (status_code)
);

// ===== test/ata_chs_lba_sector_addresser_core_tb.sv =====
// self-checking testbench of the ata chs/lba sector addresser core
// directed table then random requests over several geometries, checked against a local translator
// depends on atalba_pkg and ata_chs_lba_sector_addresser_core
module ata_chs_lba_sector_addresser_core_tb;
    import atalba_pkg::*;

    localparam int LBA_BITS = 28;
    localparam logic [ADDR_W-1:0] LBA_MASK = ADDR_W'((64'd1 << LBA_BITS) - 64'd1);
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_PHASES = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        cmd_t               cmd;
        logic [SEC_W-1:0]   sec;
        logic [CYL_W-1:0]   cyl;
        logic [HEAD_W-1:0]  head;
        logic               lba;
        logic [COUNT_W-1:0] count;
    } request_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        status_t           status;
        logic [SEC_W-1:0]  sec;
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] head;
    } outcome_t;

    typedef struct packed {
        request_t req;
        logic     known;
        outcome_t res;
    } vector_t;

    typedef struct packed {
        logic [CYL_W-1:0]    cyl;
        logic [GHEADS_W-1:0] heads;
        logic [SEC_W-1:0]    sectors;
        logic [ADDR_W-1:0]   cap;
    } geometry_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    cmd_t                  cmd = CMD_SEEK;
    logic [SEC_W-1:0]      sector_reg = '0;
    logic [CYL_W-1:0]      cyl_reg = '0;
    logic [HEAD_W-1:0]     head_reg = '0;
    logic                  lba_mode = 1'b0;
    logic [COUNT_W-1:0]    sector_count_reg = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [POS_W-1:0]      position;
    logic [1:0]            status_code;
    logic [SEC_W-1:0]      next_sector_reg;
    logic [CYL_W-1:0]      next_cyl_reg;
    logic [HEAD_W-1:0]     next_head_reg;
    logic                  cfg_we = 1'b0;
    reg_idx_t              cfg_index = REG_CYLINDERS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // local copy of the active geometry
    logic [ACYL_W-1:0]   geo_cylinders = RST_CYLINDERS;
    logic [GHEADS_W-1:0] geo_heads = RST_HEADS;
    logic [SEC_W-1:0]    geo_sectors = RST_SECTORS;
    logic [ADDR_W-1:0]   geo_capacity = RST_CAPACITY;

    outcome_t expected_results [$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned ready_left = 0;
    int unsigned ready_mode = 0;

    // last address handed back, so advances can walk across carries
    logic [SEC_W-1:0]  walk_sec = '0;
    logic [CYL_W-1:0]  walk_cyl = '0;
    logic [HEAD_W-1:0] walk_head = '0;
    logic              walk_lba = 1'b0;

    vector_t directed_tab [NUM_DIRECTED] = '{
        '{'{CMD_RECAL, 8'hAB, 16'h1234, 4'h5, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h01, 16'h0000, 4'h0}},
        '{'{CMD_RECAL, 8'hFF, 16'hFFFF, 4'hF, 1'b1, 8'hFF}, 1'b1,
          '{32'd0, STATUS_OK, 8'h00, 16'h0000, 4'h0}},
        '{'{CMD_SEEK, 8'h01, 16'h0000, 4'h0, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h01, 16'h0000, 4'h0}},
        '{'{CMD_SEEK, 8'h3F, 16'h03FF, 4'hF, 1'b0, 8'h00}, 1'b1,
          '{32'd1032191, STATUS_OK, 8'h3F, 16'h03FF, 4'hF}},
        '{'{CMD_SEEK, 8'h00, 16'h0005, 4'h2, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_RANGE, 8'h00, 16'h0005, 4'h2}},
        '{'{CMD_SEEK, 8'h01, 16'h0400, 4'h0, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_RANGE, 8'h01, 16'h0400, 4'h0}},
        '{'{CMD_SEEK, 8'h40, 16'h0000, 4'h0, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_RANGE, 8'h40, 16'h0000, 4'h0}},
        '{'{CMD_SEEK, 8'hFF, 16'hFFFF, 4'hF, 1'b0, 8'hFF}, 1'b1,
          '{32'd0, STATUS_RANGE, 8'hFF, 16'hFFFF, 4'hF}},
        '{'{CMD_SEEK, 8'h00, 16'h0000, 4'h0, 1'b1, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h00, 16'h0000, 4'h0}},
        '{'{CMD_SEEK, 8'hFF, 16'h0FBF, 4'h0, 1'b1, 8'h00}, 1'b1,
          '{32'h000FBFFF, STATUS_OK, 8'hFF, 16'h0FBF, 4'h0}},
        '{'{CMD_SEEK, 8'h00, 16'h0FC0, 4'h0, 1'b1, 8'h00}, 1'b1,
          '{32'd0, STATUS_RANGE, 8'h00, 16'h0FC0, 4'h0}},
        '{'{CMD_SEEK, 8'hFF, 16'hFFFF, 4'hF, 1'b1, 8'h00}, 1'b1,
          '{32'd0, STATUS_RANGE, 8'hFF, 16'hFFFF, 4'hF}},
        '{'{CMD_ADVANCE, 8'hFF, 16'hFFFF, 4'hF, 1'b1, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h00, 16'h0000, 4'h0}},
        '{'{CMD_ADVANCE, 8'hFF, 16'h0000, 4'h0, 1'b1, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h00, 16'h0001, 4'h0}},
        '{'{CMD_ADVANCE, 8'h05, 16'h0007, 4'h3, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h06, 16'h0007, 4'h3}},
        '{'{CMD_ADVANCE, 8'h3F, 16'h0007, 4'h3, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h01, 16'h0007, 4'h4}},
        '{'{CMD_ADVANCE, 8'h3F, 16'hFFFF, 4'hF, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h01, 16'h0000, 4'h0}},
        '{'{CMD_ADVANCE, 8'hC8, 16'h0009, 4'h2, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h01, 16'h0009, 4'h3}},
        '{'{CMD_INIT, 8'h12, 16'h3456, 4'hF, 1'b0, 8'h3F}, 1'b1,
          '{32'd0, STATUS_OK, 8'h12, 16'h3456, 4'hF}},
        '{'{CMD_INIT, 8'h00, 16'h0000, 4'h0, 1'b1, 8'hFF}, 1'b0, '0},
        '{'{CMD_SEEK, 8'hFF, 16'h0FCE, 4'h0, 1'b0, 8'h00}, 1'b0, '0},
        // zero sectors per track: geometry error, then every chs seek fails
        '{'{CMD_INIT, 8'h5A, 16'h0102, 4'h7, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_GEOM, 8'h5A, 16'h0102, 4'h7}},
        '{'{CMD_SEEK, 8'h01, 16'h0000, 4'h0, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_RANGE, 8'h01, 16'h0000, 4'h0}},
        '{'{CMD_ADVANCE, 8'h00, 16'h0003, 4'h7, 1'b0, 8'h00}, 1'b1,
          '{32'd0, STATUS_OK, 8'h01, 16'h0004, 4'h0}},
        '{'{CMD_INIT, 8'h00, 16'h0000, 4'hF, 1'b0, 8'h3F}, 1'b0, '0}
    };

    ata_chs_lba_sector_addresser_core #(
        .LBA_BITS(LBA_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .sector_reg(sector_reg),
        .cyl_reg(cyl_reg),
        .head_reg(head_reg),
        .lba_mode(lba_mode),
        .sector_count_reg(sector_count_reg),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .position(position),
        .status_code(status_code),
        .next_sector_reg(next_sector_reg),
        .next_cyl_reg(next_cyl_reg),
        .next_head_reg(next_head_reg),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // works out the result of one request and moves the geometry on
    function automatic outcome_t translate_request(request_t r);
        outcome_t o;
        logic [ADDR_W-1:0] addr;
        logic [GHEADS_W-1:0] nh;
        o.pos = '0;
        o.status = STATUS_OK;
        o.sec = r.sec;
        o.cyl = r.cyl;
        o.head = r.head;
        addr = {r.head, r.cyl, r.sec};
        case (r.cmd)
            CMD_SEEK:
            begin
                if (r.lba)
                begin
                    if ((addr & LBA_MASK) >= geo_capacity)
                        o.status = STATUS_RANGE;
                    else
                        o.pos = POS_W'(addr & LBA_MASK);
                end
                else if (ACYL_W'(r.cyl) >= geo_cylinders || GHEADS_W'(r.head) >= geo_heads ||
                         r.sec > geo_sectors || r.sec == '0)
                    o.status = STATUS_RANGE;
                else
                    o.pos = (POS_W'(r.cyl) * POS_W'(geo_heads) + POS_W'(r.head))
                            * POS_W'(geo_sectors) + POS_W'(r.sec) - 32'd1;
            end
            CMD_ADVANCE:
            begin
                if (r.lba)
                begin
                    addr = (addr & ~LBA_MASK) | ((addr + 28'd1) & LBA_MASK);
                    {o.head, o.cyl, o.sec} = addr;
                end
                else if (r.sec < geo_sectors)
                    o.sec = r.sec + 8'd1;
                else
                begin
                    // head carry, and cylinder carry past the last head
                    o.sec = 8'd1;
                    nh = GHEADS_W'(r.head) + 5'd1;
                    if (nh < geo_heads && nh <= GHEADS_W'(MAX_HEAD))
                        o.head = nh[HEAD_W-1:0];
                    else
                    begin
                        o.head = '0;
                        o.cyl = r.cyl + 16'd1;
                    end
                end
            end
            CMD_INIT:
            begin
                geo_heads = GHEADS_W'(r.head) + 5'd1;
                geo_sectors = r.count;
                if (r.count == '0)
                    o.status = STATUS_GEOM;
                else
                    geo_cylinders = geo_capacity / ADDR_W'(r.count) / ADDR_W'(geo_heads);
            end
            default:
            begin
                o.sec = r.lba ? 8'd0 : 8'd1;
                o.cyl = '0;
                o.head = '0;
            end
        endcase
        return o;
    endfunction

    // values at, around and below a limit
    function automatic logic [31:0] near_limit(logic [31:0] lim);
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return lim - 32'd1;
            2: return lim;
            3: return lim + 32'd1;
            default: return (lim == 32'd0) ? 32'd0 : 32'($urandom_range(0, lim - 32'd1));
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        logic [ADDR_W-1:0] addr;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.cmd = CMD_SEEK;
        else if (pick < 78)
            r.cmd = CMD_ADVANCE;
        else if (pick < 88)
            r.cmd = CMD_INIT;
        else
            r.cmd = CMD_RECAL;
        r.lba = 1'($urandom_range(0, 1));
        r.sec = SEC_W'($urandom);
        r.cyl = CYL_W'($urandom);
        r.head = HEAD_W'($urandom);
        r.count = COUNT_W'($urandom);
        // a quarter stays fully random, the rest aims at the geometry boundaries or walks on from the last address
        if ($urandom_range(0, 3) != 0)
        begin
            if (r.cmd == CMD_INIT)
            begin
                if ($urandom_range(0, 7) == 0)
                    r.count = '0;
            end
            else if (r.cmd == CMD_ADVANCE && $urandom_range(0, 1) == 0)
            begin
                r.sec = walk_sec;
                r.cyl = walk_cyl;
                r.head = walk_head;
                r.lba = walk_lba;
            end
            else if (r.lba)
            begin
                addr = ADDR_W'(near_limit(32'(geo_capacity)));
                if (r.cmd == CMD_ADVANCE && $urandom_range(0, 3) == 0)
                    addr = LBA_MASK;
                {r.head, r.cyl, r.sec} = addr;
            end
            else
            begin
                r.cyl = CYL_W'(near_limit(32'(geo_cylinders)));
                r.head = HEAD_W'(near_limit(32'(geo_heads)));
                r.sec = SEC_W'(near_limit(32'(geo_sectors) + 32'd1));
            end
        end
        return r;
    endfunction

    task automatic send_request(input request_t r, input logic known, input outcome_t typed);
        outcome_t o;
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= r.cmd;
        sector_reg <= r.sec;
        cyl_reg <= r.cyl;
        head_reg <= r.head;
        lba_mode <= r.lba;
        sector_count_reg <= r.count;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        o = translate_request(r);
        expected_results.push_back(known ? typed : o);
        walk_sec = o.sec;
        walk_cyl = o.cyl;
        walk_head = o.head;
        walk_lba = r.lba;
    endtask

    // hold off new requests until every result is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_CYLINDERS: geo_cylinders = ACYL_W'(value[CYL_W-1:0]);
            REG_HEADS:     geo_heads = value[GHEADS_W-1:0];
            REG_SECTORS:   geo_sectors = value[SEC_W-1:0];
            default:       geo_capacity = value[ADDR_W-1:0];
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %h %h",
                         $time, position, status_code);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("position", want.pos, position);
                check_field("status_code", 32'(want.status), 32'(status_code));
                check_field("next_sector_reg", 32'(want.sec), 32'(next_sector_reg));
                check_field("next_cyl_reg", 32'(want.cyl), 32'(next_cyl_reg));
                check_field("next_head_reg", 32'(want.head), 32'(next_head_reg));
            end
        end
    end

    // receiver stalls in modes: always ready, coin toss, mostly stalled, periodic
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(50, 300);
        end
        ready_left--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ready_left[3];
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        geometry_t plan [NUM_PHASES];
        geometry_t g;
        int unsigned p;
        int unsigned n;
        plan = '{
            '{16'd1024, 5'd16, 8'd63, 28'd1032192},
            '{16'd0, 5'd0, 8'd0, 28'd0},
            '{16'hFFFF, 5'd16, 8'd255, 28'hFFFFFFF},
            '{16'd1, 5'd1, 8'd1, 28'd1},
            '{16'd2, 5'd3, 8'd5, 28'd97},
            '{16'd300, 5'd16, 8'd17, 28'd81600},
            '{16'd0, 5'd0, 8'd0, 28'd0}
        };
        plan[NUM_PHASES-1] = '{CYL_W'($urandom_range(1, 4000)), GHEADS_W'($urandom_range(1, 16)),
                               SEC_W'($urandom_range(1, 255)), ADDR_W'($urandom)};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_tab[i])
            send_request(directed_tab[i].req, directed_tab[i].known, directed_tab[i].res);
        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            g = plan[p];
            program_reg(REG_CYLINDERS, CFG_DATA_W'(g.cyl));
            program_reg(REG_HEADS, CFG_DATA_W'(g.heads));
            program_reg(REG_SECTORS, CFG_DATA_W'(g.sectors));
            program_reg(REG_CAPACITY, CFG_DATA_W'(g.cap));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
                send_request(random_request(), 1'b0, '0);
            end
        end
        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/atalba_pkg.sv
rtl/atalba_fifo.sv
rtl/atalba_front.sv
rtl/atalba_back.sv
rtl/ata_chs_lba_sector_addresser_core.sv
rtl/atalba_checker.sv
test/ata_chs_lba_sector_addresser_core_tb.sv
